[sv/gatpe_pkg.sv]
// ----------------------------------------------------------------------------
// gatpe_pkg
// Shared widths, codes and controller/datapath bundles for the greedy ant
// tour engine.
// ----------------------------------------------------------------------------
package gatpe_pkg;

   localparam int unsigned CITY_W     = 6;
   localparam int unsigned LEN_W      = 22;
   localparam int unsigned DIST_W     = 16;
   localparam int unsigned FRAC_W     = 16;
   localparam int unsigned CNT_W      = 7;
   localparam int unsigned CMD_W      = 2;
   localparam int unsigned STAT_W     = 2;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 16;
   localparam int unsigned DIVQ_W     = 33;
   localparam int unsigned EMIT_W     = 3;

   localparam int unsigned DEF_MAX_CITIES = 32;
   localparam int unsigned DEF_MAX_ANTS   = 8;

   localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_BUILD   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DEPOSIT = 2'd2;

   localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
   localparam logic [STAT_W-1:0] STAT_UNBUILT = 2'd1;
   localparam logic [STAT_W-1:0] STAT_RANGE   = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_CITY_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DECAY      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DEPOSIT    = 2'd2;

   localparam logic [CNT_W-1:0]      CITY_COUNT_RST = 7'd32;
   localparam logic [FRAC_W-1:0]     DECAY_RST      = 16'd32768;
   localparam logic [CSR_DATA_W-1:0] DEPOSIT_RST    = 16'd100;

   localparam logic [31:0] PHER_ONE = 32'h0001_0000;
   localparam logic [31:0] SAT32    = 32'hFFFF_FFFF;

   localparam logic [EMIT_W-1:0] EM_ERR_RANGE   = 3'd0;
   localparam logic [EMIT_W-1:0] EM_ERR_UNBUILT = 3'd1;
   localparam logic [EMIT_W-1:0] EM_LOAD        = 3'd2;
   localparam logic [EMIT_W-1:0] EM_TOUR        = 3'd3;
   localparam logic [EMIT_W-1:0] EM_DEP         = 3'd4;

   typedef struct packed {
      logic              capture;
      logic              div_start;
      logic              div_inverse;
      logic              load_write;
      logic              invd_write;
      logic              tour_init;
      logic              best_clear;
      logic              scan_issue;
      logic [CITY_W-1:0] scan_idx;
      logic              dist_read;
      logic              tour_step;
      logic              slot_write;
      logic [CITY_W-1:0] path_idx;
      logic              prev_load;
      logic              curr_load;
      logic              pher_write;
      logic              emit;
      logic [EMIT_W-1:0] emit_kind;
      logic [CITY_W-1:0] pos;
      logic              last_flag;
   } dp_cmd_type;

   typedef struct packed {
      logic [CMD_W-1:0] command;
      logic             range_err;
      logic             unbuilt;
      logic [CNT_W-1:0] n_cities;
      logic [CNT_W-1:0] path_count;
      logic             div_done;
   } dp_stat_type;

endpackage

[sv/gatpe_div.sv]
// ----------------------------------------------------------------------------
// gatpe_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gatpe_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        go,
   input  logic [gatpe_pkg::DIVQ_W-1:0] dividend,
   input  logic [gatpe_pkg::LEN_W-1:0]  divisor,
   output logic                        done,
   output logic [gatpe_pkg::DIVQ_W-1:0] quotient
);
   import gatpe_pkg::*;

   localparam int unsigned STEPS = DIVQ_W;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [5:0]        cnt_ff, cnt_in;
   logic [LEN_W-1:0]  rem_ff, rem_in;
   logic [DIVQ_W-1:0] quo_ff, quo_in;
   logic [LEN_W:0]    rem_sh, diff;
   logic              ge;

   always_comb begin
      rem_sh  = {rem_ff, quo_ff[DIVQ_W-1]};
      ge      = rem_sh >= {1'b0, divisor};
      diff    = rem_sh - {1'b0, divisor};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (go) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = ge ? diff[LEN_W-1:0] : rem_sh[LEN_W-1:0];
         quo_in = {quo_ff[DIVQ_W-2:0], ge};
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

[sv/gatpe_ctrl.sv]
// ----------------------------------------------------------------------------
// gatpe_ctrl
// Command sequencer: decodes each word and steps the datapath through load,
// tour build scans and deposit passes.
// ----------------------------------------------------------------------------
module gatpe_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  gatpe_pkg::dp_stat_type  stat,
   output gatpe_pkg::dp_cmd_type   cmd
);
   import gatpe_pkg::*;

   localparam logic [4:0] S_IDLE   = 5'd0;
   localparam logic [4:0] S_DECODE = 5'd1;
   localparam logic [4:0] S_LD_DIV = 5'd2;
   localparam logic [4:0] S_B_SCAN = 5'd3;
   localparam logic [4:0] S_B_DRN1 = 5'd4;
   localparam logic [4:0] S_B_DRN2 = 5'd5;
   localparam logic [4:0] S_B_DIST = 5'd6;
   localparam logic [4:0] S_B_STEP = 5'd7;
   localparam logic [4:0] S_D_DIV  = 5'd8;
   localparam logic [4:0] S_D_RD0  = 5'd9;
   localparam logic [4:0] S_D_RDI  = 5'd10;
   localparam logic [4:0] S_D_PH   = 5'd11;
   localparam logic [4:0] S_D_MUL  = 5'd12;
   localparam logic [4:0] S_D_WR   = 5'd13;
   localparam logic [4:0] S_D_DONE = 5'd14;

   logic [4:0]       state_ff, state_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] p_ff, p_in;
   logic [CNT_W-1:0] n_last, idx_next;

   always_comb begin
      n_last   = stat.n_cities - 7'd1;
      idx_next = idx_ff + 7'd1;
      state_in = state_ff;
      idx_in   = idx_ff;
      p_in     = p_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            if (stat.range_err) begin
               cmd.emit      = 1'b1;
               cmd.emit_kind = EM_ERR_RANGE;
               state_in      = S_IDLE;
            end else if (stat.command == CMD_LOAD) begin
               cmd.load_write  = 1'b1;
               cmd.div_start   = 1'b1;
               cmd.div_inverse = 1'b1;
               state_in        = S_LD_DIV;
            end else if (stat.command == CMD_BUILD) begin
               cmd.tour_init = 1'b1;
               cmd.emit      = 1'b1;
               cmd.emit_kind = EM_TOUR;
               cmd.last_flag = (stat.n_cities == 7'd1);
               idx_in        = '0;
               p_in          = 7'd1;
               if (stat.n_cities == 7'd1) begin
                  cmd.slot_write = 1'b1;
                  state_in       = S_IDLE;
               end else begin
                  state_in = S_B_SCAN;
               end
            end else if (stat.unbuilt) begin
               cmd.emit      = 1'b1;
               cmd.emit_kind = EM_ERR_UNBUILT;
               state_in      = S_IDLE;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = S_D_DIV;
            end
         end
         S_LD_DIV: begin
            // hold the distance on the divisor while the divider runs
            cmd.div_inverse = 1'b1;
            if (stat.div_done) begin
               cmd.invd_write = 1'b1;
               cmd.emit       = 1'b1;
               cmd.emit_kind  = EM_LOAD;
               state_in       = S_IDLE;
            end
         end
         S_B_SCAN: begin
            cmd.scan_issue = 1'b1;
            cmd.scan_idx   = CITY_W'(idx_ff);
            cmd.best_clear = (idx_ff == '0);
            if (idx_ff == n_last) begin
               state_in = S_B_DRN1;
            end else begin
               idx_in = idx_next;
            end
         end
         S_B_DRN1: state_in = S_B_DRN2;
         S_B_DRN2: state_in = S_B_DIST;
         S_B_DIST: begin
            cmd.dist_read = 1'b1;
            state_in      = S_B_STEP;
         end
         S_B_STEP: begin
            cmd.tour_step = 1'b1;
            cmd.emit      = 1'b1;
            cmd.emit_kind = EM_TOUR;
            cmd.pos       = CITY_W'(p_ff);
            cmd.last_flag = (p_ff == n_last);
            idx_in        = '0;
            if (p_ff == n_last) begin
               cmd.slot_write = 1'b1;
               state_in       = S_IDLE;
            end else begin
               p_in     = p_ff + 7'd1;
               state_in = S_B_SCAN;
            end
         end
         S_D_DIV: begin
            idx_in = 7'd1;
            if (stat.div_done) begin
               state_in = (stat.path_count > 7'd1) ? S_D_RD0 : S_D_DONE;
            end
         end
         S_D_RD0: begin
            cmd.path_idx = '0;
            state_in     = S_D_RDI;
         end
         S_D_RDI: begin
            cmd.path_idx  = CITY_W'(idx_ff);
            cmd.prev_load = (idx_ff == 7'd1);
            state_in      = S_D_PH;
         end
         S_D_PH: begin
            cmd.curr_load = 1'b1;
            state_in      = S_D_MUL;
         end
         S_D_MUL: state_in = S_D_WR;
         S_D_WR: begin
            cmd.pher_write = 1'b1;
            idx_in         = idx_next;
            state_in       = (idx_next < stat.path_count) ? S_D_RDI : S_D_DONE;
         end
         S_D_DONE: begin
            cmd.emit      = 1'b1;
            cmd.emit_kind = EM_DEP;
            state_in      = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff   <= '0;
         p_ff     <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         p_ff     <= p_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

[sv/gatpe_dp.sv]
// ----------------------------------------------------------------------------
// gatpe_dp
// Datapath: edge memories, path and slot stores, scan pipeline with the
// best-score tracker, deposit arithmetic, divider and result registers.
// ----------------------------------------------------------------------------
module gatpe_dp #(
   parameter int unsigned MAX_CITIES = gatpe_pkg::DEF_MAX_CITIES,
   parameter int unsigned MAX_ANTS   = gatpe_pkg::DEF_MAX_ANTS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  gatpe_pkg::dp_cmd_type             cmd,
   output gatpe_pkg::dp_stat_type            stat,
   input  logic [gatpe_pkg::CMD_W-1:0]       req_command,
   input  logic [gatpe_pkg::CITY_W-1:0]      req_row_city,
   input  logic [gatpe_pkg::CITY_W-1:0]      req_col_city,
   input  logic [gatpe_pkg::DIST_W-1:0]      req_distance,
   input  logic [gatpe_pkg::CITY_W-1:0]      req_ant_slot,
   input  logic [gatpe_pkg::CITY_W-1:0]      req_start_city,
   input  logic                              csr_write,
   input  logic [gatpe_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [gatpe_pkg::CSR_DATA_W-1:0]  csr_data,
   output logic                              rsp_valid,
   output logic [gatpe_pkg::CITY_W-1:0]      rsp_city,
   output logic [gatpe_pkg::CITY_W-1:0]      rsp_position,
   output logic [gatpe_pkg::LEN_W-1:0]       rsp_tour_length,
   output logic [gatpe_pkg::STAT_W-1:0]      rsp_status,
   output logic                              rsp_last
);
   import gatpe_pkg::*;

   localparam int unsigned CW    = $clog2(MAX_CITIES);
   localparam int unsigned SW    = (MAX_ANTS > 1) ? $clog2(MAX_ANTS) : 1;
   localparam int unsigned EW    = 2 * CW;
   localparam int unsigned EDGES = 1 << EW;
   localparam int unsigned PW    = SW + CW;
   localparam int unsigned PDEP  = 1 << PW;
   localparam int unsigned SLW   = CNT_W + LEN_W;
   localparam logic [CNT_W-1:0] MC = CNT_W'(MAX_CITIES);
   localparam logic [CNT_W-1:0] MA = CNT_W'(MAX_ANTS);

   // configuration
   logic [CNT_W-1:0]      city_count_ff;
   logic [FRAC_W-1:0]     decay_ff;
   logic [CSR_DATA_W-1:0] deposit_ff;

   // captured request word
   logic [CMD_W-1:0]  cmd_ff;
   logic [CITY_W-1:0] row_ff, col_ff, slot_ff, start_ff;
   logic [DIST_W-1:0] dist_ff;

   // tour state
   logic [MAX_CITIES-1:0] visited_ff;
   logic [CW-1:0]         cur_ff;
   logic [LEN_W-1:0]      len_ff;
   logic [MAX_ANTS-1:0]   built_ff;

   // scan pipeline and best tracker
   logic          s1_vld_ff, s1_vis_ff, s2_vld_ff, best_vld_ff;
   logic [CW-1:0] s1_idx_ff, s2_idx_ff, best_idx_ff;
   logic [63:0]   prod_ff, best_val_ff;
   logic          take;

   // memories
   logic [31:0]     pher_mem [EDGES];
   logic [31:0]     invd_mem [EDGES];
   logic [DIST_W-1:0] dist_mem [EDGES];
   logic [CW-1:0]   path_mem [PDEP];
   logic [SLW-1:0]  slot_mem [MAX_ANTS];
   logic [31:0]     pher_q_ff, invd_q_ff;
   logic [DIST_W-1:0] dist_q_ff;
   logic [CW-1:0]   path_q_ff;
   logic [SLW-1:0]  slot_q_ff;

   // deposit
   logic [CW-1:0]        prev_ff, curr_ff;
   logic [FRAC_W+31:0]   prod2_ff;
   logic [EW-1:0]        pher_rd_addr, pher_wr_addr, load_addr;
   logic [31:0]          pher_wr_data, q_dep;
   logic [32:0]          dep_sum;
   logic                 pher_we;

   // build helpers
   logic [CNT_W-1:0]  n_cities;
   logic [LEN_W-1:0]  len_next, slot_len;
   logic [CNT_W-1:0]  slot_cnt;
   logic [PW-1:0]     path_wr_addr;
   logic [CW-1:0]     path_wr_data;
   logic              range_err;

   // divider
   logic [DIVQ_W-1:0] div_dividend, div_quo;
   logic [LEN_W-1:0]  div_divisor;
   logic              div_done;

   // result
   logic              rsp_valid_ff;
   logic [CITY_W-1:0] rsp_city_ff, rsp_pos_ff;
   logic [LEN_W-1:0]  rsp_len_ff;
   logic [STAT_W-1:0] rsp_stat_ff;
   logic              rsp_last_ff;

   always_comb begin
      if (city_count_ff == '0) begin
         n_cities = 7'd1;
      end else if (city_count_ff > MC) begin
         n_cities = MC;
      end else begin
         n_cities = city_count_ff;
      end
   end

   assign slot_len = slot_q_ff[LEN_W-1:0];
   assign slot_cnt = slot_q_ff[SLW-1:LEN_W];
   assign len_next = len_ff + LEN_W'(dist_q_ff);

   always_comb begin
      case (cmd_ff)
         CMD_LOAD:    range_err = ({1'b0, row_ff} >= MC) || ({1'b0, col_ff} >= MC);
         CMD_BUILD:   range_err = ({1'b0, slot_ff} >= MA) || ({1'b0, start_ff} >= n_cities);
         CMD_DEPOSIT: range_err = ({1'b0, slot_ff} >= MA);
         default:     range_err = 1'b1;
      endcase
   end

   assign stat.command    = cmd_ff;
   assign stat.range_err  = range_err;
   assign stat.unbuilt    = !built_ff[slot_ff[SW-1:0]];
   assign stat.n_cities   = n_cities;
   assign stat.path_count = slot_cnt;
   assign stat.div_done   = div_done;

   // shared divider: 2^32 / distance on load, (deposit << 16) / length on deposit
   assign div_dividend = cmd.div_inverse ? {1'b1, 32'd0}
                                         : {1'b0, deposit_ff, 16'd0};
   assign div_divisor  = cmd.div_inverse ? LEN_W'(dist_ff) : slot_len;

   gatpe_div u_div (
      .clock    (clock),
      .reset    (reset),
      .go       (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign q_dep   = (slot_len == '0) ? SAT32 : div_quo[31:0];
   assign dep_sum = {1'b0, prod2_ff[FRAC_W+31:FRAC_W]} + {1'b0, q_dep};

   assign load_addr    = {row_ff[CW-1:0], col_ff[CW-1:0]};
   assign pher_rd_addr = cmd.scan_issue ? {cur_ff, cmd.scan_idx[CW-1:0]}
                                        : {prev_ff, path_q_ff};
   assign pher_wr_addr = cmd.load_write ? load_addr : {prev_ff, curr_ff};
   assign pher_wr_data = cmd.load_write ? PHER_ONE
                                        : (dep_sum[32] ? SAT32 : dep_sum[31:0]);
   assign pher_we      = cmd.load_write | cmd.pher_write;

   assign path_wr_addr = cmd.tour_init ? {slot_ff[SW-1:0], CW'(0)}
                                       : {slot_ff[SW-1:0], cmd.pos[CW-1:0]};
   assign path_wr_data = cmd.tour_init ? start_ff[CW-1:0] : best_idx_ff;

   assign take = s2_vld_ff && (!best_vld_ff || (prod_ff > best_val_ff));

   // memories
   always_ff @(posedge clock) begin
      if (pher_we) begin
         pher_mem[pher_wr_addr] <= pher_wr_data;
      end
      pher_q_ff <= pher_mem[pher_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.invd_write) begin
         invd_mem[load_addr] <= (dist_ff <= 16'd1) ? SAT32 : div_quo[31:0];
      end
      invd_q_ff <= invd_mem[pher_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.load_write) begin
         dist_mem[load_addr] <= dist_ff;
      end
      if (cmd.dist_read) begin
         dist_q_ff <= dist_mem[{cur_ff, best_idx_ff}];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.tour_init || cmd.tour_step) begin
         path_mem[path_wr_addr] <= path_wr_data;
      end
      path_q_ff <= path_mem[{slot_ff[SW-1:0], cmd.path_idx[CW-1:0]}];
   end

   always_ff @(posedge clock) begin
      if (cmd.slot_write) begin
         slot_mem[slot_ff[SW-1:0]] <= {n_cities, cmd.tour_init ? LEN_W'(0) : len_next};
      end
      if (cmd.capture) begin
         slot_q_ff <= slot_mem[req_ant_slot[SW-1:0]];
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         city_count_ff <= CITY_COUNT_RST;
         decay_ff      <= DECAY_RST;
         deposit_ff    <= DEPOSIT_RST;
         built_ff      <= '0;
         visited_ff    <= '0;
         s1_vld_ff     <= 1'b0;
         s2_vld_ff     <= 1'b0;
         best_vld_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               REG_CITY_COUNT: city_count_ff <= csr_data[CNT_W-1:0];
               REG_DECAY:      decay_ff      <= csr_data;
               REG_DEPOSIT:    deposit_ff    <= csr_data;
               default:        ;
            endcase
         end
         if (cmd.slot_write) begin
            built_ff[slot_ff[SW-1:0]] <= 1'b1;
         end
         if (cmd.tour_init) begin
            visited_ff                    <= '0;
            visited_ff[start_ff[CW-1:0]]  <= 1'b1;
         end else if (cmd.tour_step) begin
            visited_ff[best_idx_ff] <= 1'b1;
         end
         s1_vld_ff <= cmd.scan_issue;
         s2_vld_ff <= s1_vld_ff && !s1_vis_ff;
         if (cmd.best_clear) begin
            best_vld_ff <= 1'b0;
         end else if (take) begin
            best_vld_ff <= 1'b1;
         end
         rsp_valid_ff <= cmd.emit;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff   <= req_command;
         row_ff   <= req_row_city;
         col_ff   <= req_col_city;
         dist_ff  <= req_distance;
         slot_ff  <= req_ant_slot;
         start_ff <= req_start_city;
      end
      if (cmd.tour_init) begin
         cur_ff <= start_ff[CW-1:0];
         len_ff <= '0;
      end else if (cmd.tour_step) begin
         cur_ff <= best_idx_ff;
         len_ff <= len_next;
      end
      s1_idx_ff <= cmd.scan_idx[CW-1:0];
      s1_vis_ff <= visited_ff[cmd.scan_idx[CW-1:0]];
      s2_idx_ff <= s1_idx_ff;
      prod_ff   <= 64'(pher_q_ff) * 64'(invd_q_ff);
      if (take) begin
         best_idx_ff <= s2_idx_ff;
         best_val_ff <= prod_ff;
      end
      if (cmd.prev_load) begin
         prev_ff <= path_q_ff;
      end else if (cmd.pher_write) begin
         prev_ff <= curr_ff;
      end
      if (cmd.curr_load) begin
         curr_ff <= path_q_ff;
      end
      prod2_ff <= (FRAC_W + 32)'(pher_q_ff) * (FRAC_W + 32)'(decay_ff);
   end

   // result word
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_city_ff <= '0;
         rsp_pos_ff  <= '0;
         rsp_len_ff  <= '0;
         rsp_stat_ff <= STAT_OK;
         rsp_last_ff <= 1'b1;
         case (cmd.emit_kind)
            EM_ERR_RANGE:   rsp_stat_ff <= STAT_RANGE;
            EM_ERR_UNBUILT: rsp_stat_ff <= STAT_UNBUILT;
            EM_TOUR: begin
               rsp_city_ff <= cmd.tour_init ? start_ff : CITY_W'(best_idx_ff);
               rsp_pos_ff  <= cmd.pos;
               rsp_len_ff  <= cmd.tour_init ? LEN_W'(0) : len_next;
               rsp_last_ff <= cmd.last_flag;
            end
            EM_DEP:  rsp_len_ff <= slot_len;
            default: ;
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_city        = rsp_city_ff;
   assign rsp_position    = rsp_pos_ff;
   assign rsp_tour_length = rsp_len_ff;
   assign rsp_status      = rsp_stat_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

[sv/greedy_ant_tour_pheromone_engine.sv]
// ----------------------------------------------------------------------------
// greedy_ant_tour_pheromone_engine
// Greedy ant-colony tour engine: distance load, tour build, pheromone deposit.
// ----------------------------------------------------------------------------
// Load: the result word waits on the 33-step divider.
// Build over n cities: a word for the start city, then a word for each step once
// the edge memory read port has scanned the n cities, one city a cycle.
// Deposit over n cities: the divider runs, then each edge is read, decayed and written back in turn.
// One command at a time; busy stays high until the last result word.
// Synchronous reset clears control state, resets configuration; results never stall.
module greedy_ant_tour_pheromone_engine #(
   parameter int unsigned MAX_CITIES = gatpe_pkg::DEF_MAX_CITIES,
   parameter int unsigned MAX_ANTS   = gatpe_pkg::DEF_MAX_ANTS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [gatpe_pkg::CMD_W-1:0]       req_command,
   input  logic [gatpe_pkg::CITY_W-1:0]      req_row_city,
   input  logic [gatpe_pkg::CITY_W-1:0]      req_col_city,
   input  logic [gatpe_pkg::DIST_W-1:0]      req_distance,
   input  logic [gatpe_pkg::CITY_W-1:0]      req_ant_slot,
   input  logic [gatpe_pkg::CITY_W-1:0]      req_start_city,
   output logic                              rsp_valid,
   output logic [gatpe_pkg::CITY_W-1:0]      rsp_city,
   output logic [gatpe_pkg::CITY_W-1:0]      rsp_position,
   output logic [gatpe_pkg::LEN_W-1:0]       rsp_tour_length,
   output logic [gatpe_pkg::STAT_W-1:0]      rsp_status,
   output logic                              rsp_last,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [gatpe_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [gatpe_pkg::CSR_DATA_W-1:0]  csr_data
);
   import gatpe_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   assign csr_ready = 1'b1;

   gatpe_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   gatpe_dp #(
      .MAX_CITIES (MAX_CITIES),
      .MAX_ANTS   (MAX_ANTS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_command     (req_command),
      .req_row_city    (req_row_city),
      .req_col_city    (req_col_city),
      .req_distance    (req_distance),
      .req_ant_slot    (req_ant_slot),
      .req_start_city  (req_start_city),
      .csr_write       (csr_valid & csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .rsp_valid       (rsp_valid),
      .rsp_city        (rsp_city),
      .rsp_position    (rsp_position),
      .rsp_tour_length (rsp_tour_length),
      .rsp_status      (rsp_status),
      .rsp_last        (rsp_last)
   );

endmodule
